>>> rtl/jac_pkg.sv
// ============================================================================
// jac_pkg: joystick axis calibrator shared definitions
// Widths, register map, reset values and the configuration bundle used by
// the register block and the datapath.
// ============================================================================
`default_nettype none

package jac_pkg;

    // Field widths
    localparam int DATA_W  = 16;                 // raw sample and axis value
    localparam int HALF_W  = 15;                 // half_scale register
    localparam int PROD_W  = DATA_W + HALF_W;    // ramp numerator
    localparam int QUO_W   = HALF_W;             // ramp quotient is below half_scale
    localparam int CNT_W   = $clog2(QUO_W);      // divider step counter

    // Configuration port
    localparam int NUM_REGS = 8;
    localparam int PDATA_W  = 32;
    localparam int ADDR_W   = $clog2(NUM_REGS) + 2;
    localparam int IDX_W    = $clog2(NUM_REGS);

    // Change and deadband thresholds are half_scale divided by these powers of two
    localparam int CHG_SHIFT  = 6;
    localparam int DEAD_SHIFT = 4;

    // Register indexes (byte address is 4 * index)
    typedef enum logic [IDX_W-1:0] {
        REG_CAL_LOW     = 3'd0,
        REG_CENTRE_LOW  = 3'd1,
        REG_CENTRE_HIGH = 3'd2,
        REG_CAL_HIGH    = 3'd3,
        REG_FULL_SCALE  = 3'd4,
        REG_HALF_SCALE  = 3'd5,
        REG_INVERT      = 3'd6,
        REG_NO_CENTER   = 3'd7
    } reg_idx_t;

    // Reset values
    localparam logic [DATA_W-1:0] RST_CAL_LOW     = 16'd0;
    localparam logic [DATA_W-1:0] RST_CENTRE_LOW  = 16'd32000;
    localparam logic [DATA_W-1:0] RST_CENTRE_HIGH = 16'd33535;
    localparam logic [DATA_W-1:0] RST_CAL_HIGH    = 16'd65535;
    localparam logic [DATA_W-1:0] RST_FULL_SCALE  = 16'd65534;
    localparam logic [HALF_W-1:0] RST_HALF_SCALE  = 15'd32767;

    // Configuration bundle from the register block to the datapath
    typedef struct packed {
        logic [DATA_W-1:0] cal_low;
        logic [DATA_W-1:0] centre_low;
        logic [DATA_W-1:0] centre_high;
        logic [DATA_W-1:0] cal_high;
        logic [DATA_W-1:0] full_scale;
        logic [HALF_W-1:0] half_scale;
        logic              invert;
        logic              no_center;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/jac_sample_if.sv
// ============================================================================
// jac_sample_if: raw sample channel
// Valid/ready channel that carries one raw converter reading per beat.
// ============================================================================
`default_nettype none

interface jac_sample_if;

    logic                         valid;
    logic                         ready;
    logic [jac_pkg::DATA_W-1:0]   raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);

endinterface

`default_nettype wire

>>> rtl/jac_result_if.sv
// ============================================================================
// jac_result_if: calibrated result channel
// Valid/ready channel that carries one calibrated axis result per beat.
// ============================================================================
`default_nettype none

interface jac_result_if;

    logic                                valid;
    logic                                ready;
    logic        [jac_pkg::DATA_W-1:0]   axis_value;
    logic signed [jac_pkg::DATA_W-1:0]   signed_value;
    logic                                changed;
    logic                                active;

    modport source (output valid, output axis_value, output signed_value,
                    output changed, output active, input ready);
    modport sink   (input valid, input axis_value, input signed_value,
                    input changed, input active, output ready);

endinterface

`default_nettype wire

>>> rtl/jac_regs.sv
// ============================================================================
// jac_regs: calibration register block
// APB-style write/read access to the eight calibration registers.
// ============================================================================
`default_nettype none

module jac_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [jac_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [jac_pkg::PDATA_W-1:0]  pwdata,
    output logic      [jac_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output jac_pkg::cfg_t                     cfg
);

    jac_pkg::cfg_t     cfg_reg;
    jac_pkg::reg_idx_t idx;
    logic              wr_en;

    // Word index from the byte address
    assign idx    = jac_pkg::reg_idx_t'(paddr[jac_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_low     <= jac_pkg::RST_CAL_LOW;
            cfg_reg.centre_low  <= jac_pkg::RST_CENTRE_LOW;
            cfg_reg.centre_high <= jac_pkg::RST_CENTRE_HIGH;
            cfg_reg.cal_high    <= jac_pkg::RST_CAL_HIGH;
            cfg_reg.full_scale  <= jac_pkg::RST_FULL_SCALE;
            cfg_reg.half_scale  <= jac_pkg::RST_HALF_SCALE;
            cfg_reg.invert      <= 1'b0;
            cfg_reg.no_center   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                jac_pkg::REG_CAL_LOW:     cfg_reg.cal_low     <= pwdata[jac_pkg::DATA_W-1:0];
                jac_pkg::REG_CENTRE_LOW:  cfg_reg.centre_low  <= pwdata[jac_pkg::DATA_W-1:0];
                jac_pkg::REG_CENTRE_HIGH: cfg_reg.centre_high <= pwdata[jac_pkg::DATA_W-1:0];
                jac_pkg::REG_CAL_HIGH:    cfg_reg.cal_high    <= pwdata[jac_pkg::DATA_W-1:0];
                jac_pkg::REG_FULL_SCALE:  cfg_reg.full_scale  <= pwdata[jac_pkg::DATA_W-1:0];
                jac_pkg::REG_HALF_SCALE:  cfg_reg.half_scale  <= pwdata[jac_pkg::HALF_W-1:0];
                jac_pkg::REG_INVERT:      cfg_reg.invert      <= pwdata[0];
                jac_pkg::REG_NO_CENTER:   cfg_reg.no_center   <= pwdata[0];
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Read-back mux
    always_comb
    begin
        unique case (idx)
            jac_pkg::REG_CAL_LOW:     prdata = jac_pkg::PDATA_W'(cfg_reg.cal_low);
            jac_pkg::REG_CENTRE_LOW:  prdata = jac_pkg::PDATA_W'(cfg_reg.centre_low);
            jac_pkg::REG_CENTRE_HIGH: prdata = jac_pkg::PDATA_W'(cfg_reg.centre_high);
            jac_pkg::REG_CAL_HIGH:    prdata = jac_pkg::PDATA_W'(cfg_reg.cal_high);
            jac_pkg::REG_FULL_SCALE:  prdata = jac_pkg::PDATA_W'(cfg_reg.full_scale);
            jac_pkg::REG_HALF_SCALE:  prdata = jac_pkg::PDATA_W'(cfg_reg.half_scale);
            jac_pkg::REG_INVERT:      prdata = jac_pkg::PDATA_W'(cfg_reg.invert);
            jac_pkg::REG_NO_CENTER:   prdata = jac_pkg::PDATA_W'(cfg_reg.no_center);
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/jac_div.sv
// ============================================================================
// jac_div: serial restoring divider
// Produces one quotient bit per cycle for a numerator known to give a
// quotient that fits in QUO_W bits.
// ============================================================================
`default_nettype none

module jac_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [jac_pkg::PROD_W-1:0]  num,
    input  wire logic [jac_pkg::DATA_W-1:0]  den,
    output logic                             done,
    output logic      [jac_pkg::QUO_W-1:0]   quo
);

    logic [jac_pkg::DATA_W-1:0] rem_reg;
    logic [jac_pkg::QUO_W-1:0]  shf_reg;
    logic [jac_pkg::DATA_W-1:0] den_reg;
    logic [jac_pkg::CNT_W-1:0]  cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [jac_pkg::DATA_W:0]   partial;
    logic [jac_pkg::DATA_W:0]   trial;
    logic                       fits;

    // One subtract-and-compare step: bring down the next numerator bit
    assign partial = {rem_reg, shf_reg[jac_pkg::QUO_W-1]};
    assign fits    = partial >= {1'b0, den_reg};
    assign trial   = partial - {1'b0, den_reg};

    assign done = done_reg;
    assign quo  = shf_reg;

    // Step sequencing. The upper numerator half is already below the divisor,
    // so it seeds the partial remainder directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            shf_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= num[jac_pkg::PROD_W-1:jac_pkg::QUO_W];
            shf_reg  <= num[jac_pkg::QUO_W-1:0];
            den_reg  <= den;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? trial[jac_pkg::DATA_W-1:0] : partial[jac_pkg::DATA_W-1:0];
            shf_reg  <= {shf_reg[jac_pkg::QUO_W-2:0], fits};
            cnt_reg  <= cnt_reg + 1'b1;
            if (cnt_reg == jac_pkg::CNT_W'(jac_pkg::QUO_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    // The divider never reports completion while it is still stepping
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("jac_div: done while busy");

    // Completion follows the final step of the divider step sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(cnt_reg) == jac_pkg::CNT_W'(jac_pkg::QUO_W - 1))
        else $error("jac_div: wrong step count");

    // The seeded partial remainder stays below the divisor on every step
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> rem_reg < den_reg)
        else $error("jac_div: partial remainder overflow");
`endif

endmodule

`default_nettype wire

>>> rtl/joystick_axis_calibrator_top.sv
// ============================================================================
// joystick_axis_calibrator_top: joystick axis calibrator
// Maps raw axis readings piecewise-linearly onto 0..full_scale with a centre
// deadband, optional mirroring, and change and activity detection.
// ============================================================================
// The block takes one raw reading at a time and is not ready while it works.
// A reading on one of the two ramps goes through classify, multiply, fifteen
// steps of the serial restoring divider, value, and flags before the block
// accepts again. Readings that clamp or fall in the centre band skip the
// multiply and divider steps. The finished result sits in an output register,
// so the next reading is accepted while a result still waits; the flag stage
// holds until that register is free.
`default_nettype none

module joystick_axis_calibrator_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    jac_sample_if.sink                        sample,
    jac_result_if.source                      result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [jac_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [jac_pkg::PDATA_W-1:0]  pwdata,
    output logic      [jac_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL,
        ST_DIV,
        ST_VAL,
        ST_FLAG
    } state_t;

    typedef enum logic [2:0] {
        RG_ZERO,
        RG_FULL,
        RG_LOW,
        RG_HIGH,
        RG_MID
    } region_t;

    jac_pkg::cfg_t cfg;

    state_t                       state_reg,  state_next;
    region_t                      region_reg, region_next;
    logic [jac_pkg::DATA_W-1:0]   raw_reg,    raw_next;
    logic [jac_pkg::DATA_W-1:0]   diff_reg,   diff_next;
    logic [jac_pkg::DATA_W-1:0]   den_reg,    den_next;
    logic [jac_pkg::DATA_W-1:0]   v_reg,      v_next;
    logic [jac_pkg::DATA_W-1:0]   last_reported_reg, last_reported_next;
    logic                         out_valid_reg, out_valid_next;
    logic [jac_pkg::DATA_W-1:0]   axis_reg,   axis_next;
    logic [jac_pkg::DATA_W-1:0]   signed_reg, signed_next;
    logic                         changed_reg, changed_next;
    logic                         active_reg,  active_next;

    logic                         accept;
    logic                         out_free;
    logic                         div_start;
    logic                         div_done;
    logic [jac_pkg::QUO_W-1:0]    div_quo;
    logic [jac_pkg::PROD_W-1:0]   prod;
    logic [jac_pkg::DATA_W-1:0]   half_ext;
    logic [jac_pkg::DATA_W-1:0]   base;
    logic [jac_pkg::DATA_W-1:0]   d_last;
    logic [jac_pkg::DATA_W-1:0]   d_half;
    logic                         chg;
    logic                         outside;

    // Configuration registers
    jac_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Shared serial divider for both ramps
    jac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Handshake and port drive
    assign sample.ready        = (state_reg == ST_IDLE);
    assign accept              = sample.valid && sample.ready;
    assign out_free            = !out_valid_reg || result.ready;
    assign result.valid        = out_valid_reg;
    assign result.axis_value   = axis_reg;
    assign result.signed_value = $signed(signed_reg);
    assign result.changed      = changed_reg;
    assign result.active       = active_reg;

    // Ramp numerator: offset into the ramp times half_scale
    assign half_ext  = {1'b0, cfg.half_scale};
    assign prod      = jac_pkg::PROD_W'(diff_reg) * jac_pkg::PROD_W'(cfg.half_scale);
    assign div_start = (state_reg == ST_MUL);

    // Value before mirroring, by region
    always_comb
    begin
        case (region_reg)
            RG_ZERO: base = '0;
            RG_FULL: base = cfg.full_scale;
            RG_LOW:  base = jac_pkg::DATA_W'(div_quo);
            RG_HIGH: base = half_ext + jac_pkg::DATA_W'(div_quo);
            default: base = half_ext;
        endcase
    end

    // Distances for the change and deadband tests
    assign d_last  = (v_reg >= last_reported_reg) ? v_reg - last_reported_reg
                                                  : last_reported_reg - v_reg;
    assign d_half  = (v_reg >= half_ext) ? v_reg - half_ext : half_ext - v_reg;
    assign chg     = d_last > (half_ext >> jac_pkg::CHG_SHIFT);
    assign outside = d_half >= (half_ext >> jac_pkg::DEAD_SHIFT);

    // Sequencer next-state logic
    always_comb
    begin
        state_next         = state_reg;
        region_next        = region_reg;
        raw_next           = raw_reg;
        diff_next          = diff_reg;
        den_next           = den_reg;
        v_next             = v_reg;
        last_reported_next = last_reported_reg;
        out_valid_next     = out_valid_reg && !result.ready;
        axis_next          = axis_reg;
        signed_next        = signed_reg;
        changed_next       = changed_reg;
        active_next        = active_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    raw_next   = sample.raw_sample;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                // Tests in priority order: clamps first, then the two ramps
                if (raw_reg <= cfg.cal_low)
                begin
                    region_next = RG_ZERO;
                    state_next  = ST_VAL;
                end
                else if (raw_reg >= cfg.cal_high)
                begin
                    region_next = RG_FULL;
                    state_next  = ST_VAL;
                end
                else if (raw_reg < cfg.centre_low)
                begin
                    region_next = RG_LOW;
                    diff_next   = raw_reg - cfg.cal_low;
                    den_next    = cfg.centre_low - cfg.cal_low;
                    state_next  = ST_MUL;
                end
                else if (raw_reg > cfg.centre_high)
                begin
                    region_next = RG_HIGH;
                    diff_next   = raw_reg - cfg.centre_high;
                    den_next    = cfg.cal_high - cfg.centre_high;
                    state_next  = ST_MUL;
                end
                else
                begin
                    region_next = RG_MID;
                    state_next  = ST_VAL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_VAL;
                end
            end
            ST_VAL:
            begin
                v_next     = cfg.invert ? cfg.full_scale - base : base;
                state_next = ST_FLAG;
            end
            ST_FLAG:
            begin
                // Wait for the output register to free up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    axis_next      = v_reg;
                    signed_next    = v_reg - half_ext;
                    changed_next   = chg;
                    active_next    = chg && outside && !cfg.no_center;
                    if (chg)
                    begin
                        last_reported_next = v_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            region_reg        <= RG_ZERO;
            raw_reg           <= '0;
            diff_reg          <= '0;
            den_reg           <= '0;
            v_reg             <= '0;
            last_reported_reg <= '0;
            out_valid_reg     <= 1'b0;
            axis_reg          <= '0;
            signed_reg        <= '0;
            changed_reg       <= 1'b0;
            active_reg        <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            region_reg        <= region_next;
            raw_reg           <= raw_next;
            diff_reg          <= diff_next;
            den_reg           <= den_next;
            v_reg             <= v_next;
            last_reported_reg <= last_reported_next;
            out_valid_reg     <= out_valid_next;
            axis_reg          <= axis_next;
            signed_reg        <= signed_next;
            changed_reg       <= changed_next;
            active_reg        <= active_next;
        end
    end

`ifndef SYNTHESIS
    // A result flagged as changed is the value now held as last reported
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && changed_reg) |-> last_reported_reg == axis_reg)
        else $error("calibrator: last reported value out of step with result");

    // Activity is only ever flagged together with a change
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && active_reg) |-> changed_reg)
        else $error("calibrator: active without changed");

    // A ramp quotient never exceeds the centre value
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> div_quo <= cfg.half_scale)
        else $error("calibrator: ramp quotient out of range");

    // The divider only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("calibrator: divider result not awaited");
`endif

endmodule

`default_nettype wire
